// ===== design/smpg_pkg.sv =====
// ----------------------------------------------------------------------------
// smpg_pkg
// Shared types and constants for the segment max pool gradient router.
// ----------------------------------------------------------------------------
package smpg_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = 16;
    localparam int VAL_W       = 32;
    localparam int ENTRY_W     = VAL_W + ROW_W;

    // Most negative Q16.16 value, the empty-segment maximum.
    localparam logic signed [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic {
        CMD_FEATURE  = 1'b0,
        CMD_GRADIENT = 1'b1
    } t_cmd;

    // One per-column memory entry: running maximum and its arg-max row.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ROW_W-1:0]        row;
    } t_entry;

    localparam t_entry RESET_ENTRY = '{value: MOST_NEG, row: '0};

endpackage

// ===== design/smpg_ram.sv =====
// ----------------------------------------------------------------------------
// smpg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smpg_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/segment_max_pool_grad_router_core.sv =====
// ----------------------------------------------------------------------------
// segment_max_pool_grad_router_core
// Backward pass of segment max pooling: tracks per-column arg-max rows and
// routes each pooled gradient to the arg-max row of its column.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per item:
//   command 0 is a feature element (row, column, value), command 1 is the
//   pooled gradient that closes a column's segment. Only gradient
//   transactions produce an output transaction (o_out_valid / i_out_stall)
//   with the arg-max row, the column and the unchanged gradient value.
//   Ties keep the earliest row; an empty segment routes to row 0.
// Pipeline / throughput:
//   A gradient passes through the update stage and then the output register.
//   One transaction per cycle sustained unless the input stalls: the column
//   entry is read at accept, compared and written back when the update stage
//   advances, with a one-deep bypass for back-to-back hits on the same column.
// Reset:
//   Synchronous, active low. Per-column valid flops are cleared, so every
//   column reads as (most negative, row 0) without a clearing pass. The
//   input is stalled while reset is held.
// Receiver stall:
//   Results wait in the output register. Feature transactions keep flowing;
//   a gradient waits in the update stage and the input stalls only then.
// ----------------------------------------------------------------------------
module segment_max_pool_grad_router_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [smpg_pkg::ROW_W-1:0]          i_row,
    input  logic [smpg_pkg::COL_W-1:0]          i_column,
    input  logic signed [smpg_pkg::VAL_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [smpg_pkg::ROW_W-1:0]          o_grad_row,
    output logic [smpg_pkg::COL_W-1:0]          o_grad_column,
    output logic signed [smpg_pkg::VAL_W-1:0]   o_grad_value
);

    import smpg_pkg::*;

    // input accept and update stage handshake
    logic in_accept;
    logic s1_adv;
    logic s1_is_grad;

    // update stage (entry read data lands here)
    logic                    r_s1_valid;
    logic                    r_s1_cmd;
    logic [ROW_W-1:0]        r_s1_row;
    logic [COL_W-1:0]        r_s1_col;
    logic signed [VAL_W-1:0] r_s1_value;

    // bypass of the write that collided with this stage's read
    logic   r_s1_fwd;
    t_entry r_fwd_entry;

    // per-column "entry has been written since reset"
    logic [MAX_COLUMNS-1:0] r_vld;

    // output register
    logic                    r_out_valid;
    logic [ROW_W-1:0]        r_out_row;
    logic [COL_W-1:0]        r_out_col;
    logic signed [VAL_W-1:0] r_out_value;

    logic [ENTRY_W-1:0] rd_data;
    t_entry             n_cur;
    t_entry             n_entry;

    assign s1_is_grad = (r_s1_cmd == CMD_GRADIENT);
    // features never need the output; gradients need a free output slot
    assign s1_adv     = r_s1_valid && (!s1_is_grad || !r_out_valid || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_s1_valid && !s1_adv);
    assign in_accept  = i_in_valid && !o_in_stall;

    smpg_ram #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (n_entry),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_column),
        .o_rd_data (rd_data)
    );

    // current column entry: bypass > stored > reset value
    always_comb begin
        priority if (r_s1_fwd) begin
            n_cur = r_fwd_entry;
        end else if (r_vld[r_s1_col]) begin
            n_cur = t_entry'(rd_data);
        end else begin
            n_cur = RESET_ENTRY;
        end
    end

    // modify: a gradient resets the entry; strict greater-than keeps the earliest row on ties
    always_comb begin
        priority if (s1_is_grad) begin
            n_entry = RESET_ENTRY;
        end else if (r_s1_value > n_cur.value) begin
            n_entry = '{value: r_s1_value, row: r_s1_row};
        end else begin
            n_entry = n_cur;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_fwd    <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_s1_fwd   <= s1_adv && (r_s1_col == i_column);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_vld[r_s1_col] <= 1'b1;
            end

            if (s1_adv && s1_is_grad) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd    <= i_command;
            r_s1_row    <= i_row;
            r_s1_col    <= i_column;
            r_s1_value  <= i_value;
            r_fwd_entry <= n_entry;
        end
        if (s1_adv && s1_is_grad) begin
            r_out_row   <= n_cur.row;
            r_out_col   <= r_s1_col;
            r_out_value <= r_s1_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_grad_row    = r_out_row;
    assign o_grad_column = r_out_col;
    assign o_grad_value  = r_out_value;

endmodule

// ===== design/smpg_checker.sv =====
// ----------------------------------------------------------------------------
// smpg_checker
// Port-level assertions for the segment max pool gradient router.
// ----------------------------------------------------------------------------
module smpg_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                i_command,
    input logic [smpg_pkg::COL_W-1:0]          i_column,
    input logic signed [smpg_pkg::VAL_W-1:0]   i_value,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [smpg_pkg::ROW_W-1:0]          o_grad_row,
    input logic [smpg_pkg::COL_W-1:0]          o_grad_column,
    input logic signed [smpg_pkg::VAL_W-1:0]   o_grad_value
);

    import smpg_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_grad_row)
            && $stable(o_grad_column) && $stable(o_grad_value))
        else $error("stalled result changed");

    // a fresh result follows an accepted gradient transaction
    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && !o_in_stall && i_command == CMD_GRADIENT, 2))
        else $error("result without gradient transaction");

    // and carries that transaction's column and value
    a_rise_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            o_grad_column == $past(i_column, 2) && o_grad_value == $past(i_value, 2))
        else $error("result column or value mismatch");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind segment_max_pool_grad_router_core smpg_checker u_smpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_command     (i_command),
    .i_column      (i_column),
    .i_value       (i_value),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_grad_row    (o_grad_row),
    .o_grad_column (o_grad_column),
    .o_grad_value  (o_grad_value)
);
